[hw/rtl/bpc_pkg.sv]
// Shared types and constants for the pressure compensation core.
package bpc_pkg;

  localparam int DIV_W      = 32;
  localparam int DIV_STAGES = 32;
  localparam int SIDE_W     = 48;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [29:0] B6_OFS    = 30'd4000;
  localparam logic [15:0] RECIP10   = 16'd52429;
  localparam logic [15:0] RECIP5    = 16'd52429;
  localparam logic [19:0] RECIP100  = 20'd671089;
  localparam logic [14:0] B7_MUL    = 15'd25000;
  localparam logic [11:0] P_C1      = 12'd3038;
  localparam logic [12:0] P_C2      = 13'd7357;
  localparam logic [47:0] P_C3      = 48'd3791;
  localparam logic [17:0] PA_MAX    = 18'h3ffff;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_AC1_AC2 = 3'd0,
    CFG_AC3_AC4 = 3'd1,
    CFG_AC5_AC6 = 3'd2,
    CFG_B1_B2   = 3'd3,
    CFG_MC_MD   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic              valid;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den;
    logic [SIDE_W-1:0] side;
  } div_in_t;

  typedef struct packed {
    logic              valid;
    logic [DIV_W-1:0]  quo;
    logic [SIDE_W-1:0] side;
  } div_out_t;

endpackage

[hw/rtl/barometric_pressure_compensation_core.sv]
// Top level: calibration registers and the compensation pipeline.
//
//  channel  dir  handshake              payload
//  s_axis   in   tvalid/tready          tdata: raw_temp, raw_pressure
//  m_axis   out  tvalid/tready          tdata: temps, pressures; tuser: div_error
//  cfg      in   cfg_we                 cfg_addr, cfg_wdata
//
// One word per cycle while m_axis is not stalled; the pipeline is two 32-stage
// dividers (temperature and pressure) plus 18 arithmetic stages.
// Synchronous reset clears all valid bits and the calibration registers.
// A stall on m_axis freezes the whole pipeline; s_axis_tready drops with it.
module barometric_pressure_compensation_core import bpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [39:0]           s_axis_tdata,  // raw_temp[15:0], raw_pressure[39:16]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // temp_tenths[15:0], temp_celsius[28:16], temp_fahrenheit[42:29],
  // pressure_pa[60:43], pressure_hpa[72:61], zero[79:73]
  output logic [79:0]           m_axis_tdata,
  output logic                  m_axis_tuser,  // div_error[0]
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [31:0] cal_ac1_ac2, cal_ac3_ac4, cal_ac5_ac6, cal_b1_b2, cal_mc_md;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac1_ac2 <= '0;
      cal_ac3_ac4 <= '0;
      cal_ac5_ac6 <= '0;
      cal_b1_b2   <= '0;
      cal_mc_md   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_AC1_AC2: cal_ac1_ac2 <= cfg_wdata;
        CFG_AC3_AC4: cal_ac3_ac4 <= cfg_wdata;
        CFG_AC5_AC6: cal_ac5_ac6 <= cfg_wdata;
        CFG_B1_B2:   cal_b1_b2   <= cfg_wdata;
        CFG_MC_MD:   cal_mc_md   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic        [15:0] ac4, ac5, ac6;

  assign ac1 = cal_ac1_ac2[31:16];
  assign ac2 = cal_ac1_ac2[15:0];
  assign ac3 = cal_ac3_ac4[31:16];
  assign ac4 = cal_ac3_ac4[15:0];
  assign ac5 = cal_ac5_ac6[31:16];
  assign ac6 = cal_ac5_ac6[15:0];
  assign b1  = cal_b1_b2[31:16];
  assign b2  = cal_b1_b2[15:0];
  assign mc  = cal_mc_md[31:16];
  assign md  = cal_mc_md[15:0];

  logic en;
  logic out_v;

  assign en            = !out_v || m_axis_tready;
  assign s_axis_tready = en;

  // stage registers
  logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v, s7_v, s8_v, s9_v, s10_v;
  logic s11_v, s12_v, s13_v, s14_v, s15_v, s16_v, s17_v;

  logic        [15:0] s1_ut;
  logic        [16:0] s1_up, s2_up, s3_up, s4_up, s5_up, s6_up, s7_up, s8_up;
  logic        [16:0] s9_up, s10_up, s11_up, s12_up;
  logic signed [16:0] s2_d;
  logic signed [33:0] s3_prod;
  logic        [26:0] s4_nmag;
  logic        [19:0] s4_dmag;
  logic signed [18:0] s4_x1;
  logic               s4_qneg, s4_err;
  logic signed [28:0] s5_b5;
  logic s5_err, s6_err, s7_err, s8_err, s9_err, s10_err, s11_err, s12_err;
  logic s13_err, s14_err;
  logic signed [29:0] s6_b6;
  logic        [15:0] s6_t, s7_t, s8_t, s9_t, s10_t, s11_t, s12_t, s13_t, s14_t;
  logic signed [59:0] s7_sqp;
  logic signed [45:0] s7_a2, s7_a3;
  logic        [12:0] s7_cmag;
  logic        [46:0] s8_sq;
  logic signed [34:0] s8_x2a, s9_x2a, s10_x2a;
  logic signed [32:0] s8_x1c, s9_x1c, s10_x1c;
  logic signed [12:0] s8_c, s9_c, s10_c, s11_c, s12_c, s13_c, s14_c;
  logic        [14:0] s8_fmag;
  logic               s8_fneg, s9_fneg;
  logic signed [40:0] s9_b2h, s9_b1h;
  logic signed [39:0] s9_b2l, s9_b1l;
  logic        [12:0] s9_fq;
  logic signed [63:0] s10_b2sq, s10_b1sq;
  logic signed [13:0] s10_f, s11_f, s12_f, s13_f, s14_f;
  logic signed [53:0] s11_x3;
  logic signed [48:0] s11_sump;
  logic        [31:0] s12_b3, s12_x3m;
  logic        [16:0] s13_b4, s14_b4;
  logic        [31:0] s13_b7pre, s14_b7;
  logic        [32:0] s15_p, s16_p;
  logic        [49:0] s15_x1sq;
  logic signed [46:0] s15_x2m;
  logic        [45:0] s16_x1b;
  logic signed [30:0] s16_x2;
  logic        [17:0] s17_pa;
  logic [SIDE_W-1:0]  s15_side, s16_side, s17_side;

  // combinational helpers
  logic signed [18:0] c4_x1;
  logic signed [19:0] c4_den;
  logic        [19:0] c4_dmag;
  logic        [26:0] c4_nmag;
  div_in_t            tdin, pdin;
  div_out_t           tdout, pdout;
  logic signed [18:0] c5_x1;
  logic        [26:0] c5_q;
  logic signed [27:0] c5_x2;
  logic signed [29:0] c6_tt;
  logic signed [25:0] c6_t26;
  logic        [15:0] c6_t;
  logic        [15:0] c7_tmag;
  logic        [31:0] c7_prod;
  logic signed [12:0] c8_c;
  logic signed [15:0] c8_fnum;
  logic        [30:0] c9_fprod;
  logic        [53:0] c12_x3p1;
  logic        [47:0] c13_prod;
  logic        [46:0] c14_prod;
  logic        [32:0] c15_p;
  logic        [45:0] c15_m;
  logic        [61:0] c16_x1m;
  logic signed [47:0] c17_s;
  logic signed [48:0] c17_pn;
  logic        [17:0] c17_pa;
  logic        [37:0] c18_h;

  always_comb begin
    c4_x1   = s3_prod[33:15];
    c4_den  = {c4_x1[18], c4_x1} + {{4{md[15]}}, md};
    c4_dmag = c4_den[19] ? 20'(-c4_den) : c4_den;
    c4_nmag = mc[15] ? 27'(-$signed({mc, 11'b0})) : {mc, 11'b0};

    tdin.valid = s4_v;
    tdin.num   = {5'b0, s4_nmag};
    tdin.den   = {12'b0, s4_dmag};
    tdin.side  = {10'b0, s4_up, s4_x1, s4_qneg, s4_err};

    c5_x1 = tdout.side[20:2];
    c5_q  = tdout.quo[26:0];
    c5_x2 = tdout.side[1] ? -$signed({1'b0, c5_q}) : $signed({1'b0, c5_q});

    c6_tt  = {s5_b5[28], s5_b5} + 30'sd8;
    c6_t26 = c6_tt[29:4];
    if (c6_t26 > 26'sd32767) begin
      c6_t = 16'h7fff;
    end else if (c6_t26 < -26'sd32768) begin
      c6_t = 16'h8000;
    end else begin
      c6_t = c6_t26[15:0];
    end

    c7_tmag = s6_t[15] ? 16'(-s6_t) : s6_t;
    c7_prod = c7_tmag * RECIP10;

    c8_c    = s7_t[15] ? -$signed(s7_cmag) : $signed(s7_cmag);
    c8_fnum = {{3{c8_c[12]}}, c8_c} * 16'sd9 + 16'sd160;

    c9_fprod = s8_fmag * RECIP5;

    c12_x3p1 = s11_x3 + 54'sd1;

    c13_prod = ac4 * s12_x3m;
    c14_prod = s13_b7pre * B7_MUL;

    pdin.valid = s14_v;
    pdin.num   = s14_b7[31] ? s14_b7 : {s14_b7[30:0], 1'b0};
    pdin.den   = {15'b0, s14_b4};
    pdin.side  = {3'b0, s14_b7[31], s14_f, s14_c, s14_t, s14_err};

    c15_p = pdout.side[44] ? {pdout.quo, 1'b0} : {1'b0, pdout.quo};
    c15_m = c15_p * P_C2;

    c16_x1m = s15_x1sq * P_C1;

    c17_s  = $signed({2'b0, s16_x1b}) + {{17{s16_x2[30]}}, s16_x2} + $signed(P_C3);
    c17_pn = $signed({16'b0, s16_p}) + {{5{c17_s[47]}}, c17_s[47:4]};
    if (c17_pn[48]) begin
      c17_pa = '0;
    end else if (c17_pn > $signed({31'b0, PA_MAX})) begin
      c17_pa = PA_MAX;
    end else begin
      c17_pa = c17_pn[17:0];
    end

    c18_h = s17_pa * RECIP100;
  end

  bpc_div u_tdiv (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (tdin),
    .dout (tdout)
  );

  bpc_div u_pdiv (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (pdin),
    .dout (pdout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_v  <= 1'b0;
      s5_v  <= 1'b0;
      s6_v  <= 1'b0;
      s7_v  <= 1'b0;
      s8_v  <= 1'b0;
      s9_v  <= 1'b0;
      s10_v <= 1'b0;
      s11_v <= 1'b0;
      s12_v <= 1'b0;
      s13_v <= 1'b0;
      s14_v <= 1'b0;
      s15_v <= 1'b0;
      s16_v <= 1'b0;
      s17_v <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      s1_v  <= s_axis_tvalid;
      s2_v  <= s1_v;
      s3_v  <= s2_v;
      s4_v  <= s3_v;
      s5_v  <= tdout.valid;
      s6_v  <= s5_v;
      s7_v  <= s6_v;
      s8_v  <= s7_v;
      s9_v  <= s8_v;
      s10_v <= s9_v;
      s11_v <= s10_v;
      s12_v <= s11_v;
      s13_v <= s12_v;
      s14_v <= s13_v;
      s15_v <= pdout.valid;
      s16_v <= s15_v;
      s17_v <= s16_v;
      out_v <= s17_v;
    end
  end

  logic [15:0] o_t;
  logic [12:0] o_c;
  logic [13:0] o_f;
  logic [17:0] o_pa;
  logic [11:0] o_hpa;
  logic        o_err;

  always_ff @(posedge clk) begin
    if (en) begin
      // temperature front end
      s1_ut   <= s_axis_tdata[15:0];
      s1_up   <= s_axis_tdata[39:23];
      s2_d    <= $signed({1'b0, s1_ut}) - $signed({1'b0, ac6});
      s2_up   <= s1_up;
      s3_prod <= s2_d * $signed({1'b0, ac5});
      s3_up   <= s2_up;
      s4_nmag <= c4_nmag;
      s4_dmag <= c4_dmag;
      s4_x1   <= c4_x1;
      s4_qneg <= mc[15] ^ c4_den[19];
      s4_err  <= (c4_den == 20'sd0);
      s4_up   <= s3_up;

      // B5, B6, temperature outputs
      s5_b5  <= {{10{c5_x1[18]}}, c5_x1} + {c5_x2[27], c5_x2};
      s5_up  <= tdout.side[37:21];
      s5_err <= tdout.side[0];

      s6_b6  <= {s5_b5[28], s5_b5} - $signed(B6_OFS);
      s6_t   <= c6_t;
      s6_up  <= s5_up;
      s6_err <= s5_err;

      s7_sqp  <= s6_b6 * s6_b6;
      s7_a2   <= s6_b6 * ac2;
      s7_a3   <= s6_b6 * ac3;
      s7_cmag <= c7_prod[31:19];
      s7_t    <= s6_t;
      s7_up   <= s6_up;
      s7_err  <= s6_err;

      s8_sq   <= s7_sqp[58:12];
      s8_x2a  <= s7_a2[45:11];
      s8_x1c  <= s7_a3[45:13];
      s8_c    <= c8_c;
      s8_fmag <= c8_fnum[15] ? 15'(-c8_fnum) : c8_fnum[14:0];
      s8_fneg <= c8_fnum[15];
      s8_t    <= s7_t;
      s8_up   <= s7_up;
      s8_err  <= s7_err;

      // B2*sq and B1*sq as split partial products
      s9_b2h  <= b2 * $signed({1'b0, s8_sq[46:23]});
      s9_b2l  <= b2 * $signed({1'b0, s8_sq[22:0]});
      s9_b1h  <= b1 * $signed({1'b0, s8_sq[46:23]});
      s9_b1l  <= b1 * $signed({1'b0, s8_sq[22:0]});
      s9_fq   <= c9_fprod[30:18];
      s9_fneg <= s8_fneg;
      s9_x2a  <= s8_x2a;
      s9_x1c  <= s8_x1c;
      s9_c    <= s8_c;
      s9_t    <= s8_t;
      s9_up   <= s8_up;
      s9_err  <= s8_err;

      s10_b2sq <= $signed({s9_b2h, 23'b0}) + {{24{s9_b2l[39]}}, s9_b2l};
      s10_b1sq <= $signed({s9_b1h, 23'b0}) + {{24{s9_b1l[39]}}, s9_b1l};
      s10_f    <= s9_fneg ? -$signed({1'b0, s9_fq}) : $signed({1'b0, s9_fq});
      s10_x2a  <= s9_x2a;
      s10_x1c  <= s9_x1c;
      s10_c    <= s9_c;
      s10_t    <= s9_t;
      s10_up   <= s9_up;
      s10_err  <= s9_err;

      // X3 sums
      s11_x3   <= {s10_b2sq[63], s10_b2sq[63:11]}
                  + {{19{s10_x2a[34]}}, s10_x2a};
      s11_sump <= {{16{s10_x1c[32]}}, s10_x1c}
                  + {s10_b1sq[63], s10_b1sq[63:16]} + 49'sd2;
      s11_f    <= s10_f;
      s11_c    <= s10_c;
      s11_t    <= s10_t;
      s11_up   <= s10_up;
      s11_err  <= s10_err;

      // B3 and X3 + 32768, modulo 2^32
      s12_b3  <= {{15{ac1[15]}}, ac1, 1'b0} + c12_x3p1[32:1];
      s12_x3m <= s11_sump[33:2] + 32'd32768;
      s12_f   <= s11_f;
      s12_c   <= s11_c;
      s12_t   <= s11_t;
      s12_up  <= s11_up;
      s12_err <= s11_err;

      s13_b4    <= c13_prod[31:15];
      s13_b7pre <= {15'b0, s12_up} - s12_b3;
      s13_f     <= s12_f;
      s13_c     <= s12_c;
      s13_t     <= s12_t;
      s13_err   <= s12_err;

      s14_b7  <= c14_prod[31:0];
      s14_b4  <= s13_b4;
      s14_err <= s13_err || (s13_b4 == 17'd0);
      s14_f   <= s13_f;
      s14_c   <= s13_c;
      s14_t   <= s13_t;

      // pressure back end
      s15_p    <= c15_p;
      s15_x1sq <= c15_p[32:8] * c15_p[32:8];
      s15_x2m  <= -$signed({1'b0, c15_m});
      s15_side <= pdout.side;

      s16_x1b  <= c16_x1m[61:16];
      s16_x2   <= s15_x2m[46:16];
      s16_p    <= s15_p;
      s16_side <= s15_side;

      s17_pa   <= c17_pa;
      s17_side <= s16_side;

      o_err <= s17_side[0];
      if (s17_side[0]) begin
        o_t   <= '0;
        o_c   <= '0;
        o_f   <= '0;
        o_pa  <= '0;
        o_hpa <= '0;
      end else begin
        o_t   <= s17_side[16:1];
        o_c   <= s17_side[29:17];
        o_f   <= s17_side[43:30];
        o_pa  <= s17_pa;
        o_hpa <= c18_h[37:26];
      end
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {7'b0, o_hpa, o_pa, o_f, o_c, o_t};
  assign m_axis_tuser  = o_err;

endmodule

[hw/rtl/bpc_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
module bpc_div import bpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  div_in_t  din,
  output div_out_t dout
);

  logic [DIV_STAGES-1:0] v;
  logic [DIV_W-1:0]      rem  [DIV_STAGES];
  logic [DIV_W-1:0]      nq   [DIV_STAGES];
  logic [DIV_W-1:0]      den  [DIV_STAGES];
  logic [SIDE_W-1:0]     side [DIV_STAGES];

  logic [DIV_STAGES-1:0] src_v;
  logic [DIV_W-1:0]      src_rem  [DIV_STAGES];
  logic [DIV_W-1:0]      src_nq   [DIV_STAGES];
  logic [DIV_W-1:0]      src_den  [DIV_STAGES];
  logic [SIDE_W-1:0]     src_side [DIV_STAGES];
  logic [DIV_W-1:0]      rem_next [DIV_STAGES];
  logic [DIV_W-1:0]      nq_next  [DIV_STAGES];

  always_comb begin
    src_v[0]    = din.valid;
    src_rem[0]  = '0;
    src_nq[0]   = din.num;
    src_den[0]  = din.den;
    src_side[0] = din.side;
    for (int i = 1; i < DIV_STAGES; i++) begin
      src_v[i]    = v[i-1];
      src_rem[i]  = rem[i-1];
      src_nq[i]   = nq[i-1];
      src_den[i]  = den[i-1];
      src_side[i] = side[i-1];
    end
  end

  always_comb begin
    logic [DIV_W:0]   shifted;
    logic [DIV_W+1:0] diff;
    for (int i = 0; i < DIV_STAGES; i++) begin
      shifted = {src_rem[i], src_nq[i][DIV_W-1]};
      diff    = {1'b0, shifted} - {2'b0, src_den[i]};
      if (!diff[DIV_W+1]) begin
        rem_next[i] = diff[DIV_W-1:0];
        nq_next[i]  = {src_nq[i][DIV_W-2:0], 1'b1};
      end else begin
        rem_next[i] = shifted[DIV_W-1:0];
        nq_next[i]  = {src_nq[i][DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= src_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        rem[i]  <= rem_next[i];
        nq[i]   <= nq_next[i];
        den[i]  <= src_den[i];
        side[i] <= src_side[i];
      end
    end
  end

  assign dout.valid = v[DIV_STAGES-1];
  assign dout.quo   = nq[DIV_STAGES-1];
  assign dout.side  = side[DIV_STAGES-1];

endmodule
